>>> hdl/spq_pkg.sv
// Package for the sorted priority queue: sizes, codes and shared types.
`timescale 1ns / 1ps
package spq_pkg;

   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [COUNT_WIDTH-1:0]        count_type;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_EMPTY = 2'd2
   } err_type;

   typedef struct packed {
      logic push_en;
      logic pop_en;
   } cell_ctl_type;

endpackage

>>> hdl/spq_cell.sv
// One storage cell of the sorted chain; cell 0 holds the largest value.
`timescale 1ns / 1ps
module spq_cell (
   input  logic                 clock,
   input  spq_pkg::cell_ctl_type ctl,
   input  spq_pkg::value_type   new_value,
   input  logic                 occupied,
   input  logic                 prev_gt,
   input  spq_pkg::value_type   prev_value,
   input  spq_pkg::value_type   next_value,
   output logic                 gt,
   output spq_pkg::value_type   value_q,
   output spq_pkg::value_type   value_next
);
   import spq_pkg::*;

   value_type value_ff;
   value_type value_in;

   // New value goes in ahead of this entry when larger, or when the cell is free.
   assign gt = !occupied || (new_value > value_ff);

   always_comb begin
      value_in = value_ff;
      if (ctl.push_en) begin
         if (prev_gt) begin
            value_in = prev_value;
         end else if (gt) begin
            value_in = new_value;
         end
      end else if (ctl.pop_en) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_q    = value_ff;
   assign value_next = value_in;

endmodule

>>> hdl/sorted_priority_queue.sv
// Top level: sorted max-priority queue built as a chain of compare-and-shift cells.
// The response strobe is registered and comes in the cycle after a transaction is accepted.
// Throughput: one push or pop every cycle; all cells compare against the new value
// in parallel and shift by one position, so busy stays low.
// Reset clears the entry count and the response strobe only; cell contents stay undefined until written.
// The receiver cannot stall; each response is valid for exactly one cycle.
`timescale 1ns / 1ps
module sorted_priority_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_operation,
   input  logic signed [31:0]        req_value,
   output logic                      rsp_strobe,
   output logic signed [31:0]        rsp_popped_value,
   output logic signed [31:0]        rsp_top_value,
   output logic                      rsp_top_valid,
   output logic [4:0]                rsp_entry_count,
   output logic [1:0]                rsp_error_code
);
   import spq_pkg::*;

   count_type    count_ff, count_in;
   logic         accept, push_ok, pop_ok, is_full, is_empty;
   cell_ctl_type ctl;
   err_type      err_in;

   value_type val_q    [DEPTH];
   value_type val_next [DEPTH];
   logic [DEPTH-1:0] gt;
   logic [DEPTH-1:0] occ;

   logic      strobe_ff;
   value_type popped_ff, top_ff;
   logic      top_valid_ff;
   count_type count_rsp_ff;
   err_type   err_ff;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign is_full  = (count_ff == count_type'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign push_ok  = accept && (op_type'(req_operation) == OP_PUSH) && !is_full;
   assign pop_ok   = accept && (op_type'(req_operation) == OP_POP) && !is_empty;

   assign ctl.push_en = push_ok;
   assign ctl.pop_en  = pop_ok;

   always_comb begin
      count_in = count_ff;
      if (push_ok) begin
         count_in = count_ff + count_type'(1);
      end else if (pop_ok) begin
         count_in = count_ff - count_type'(1);
      end
   end

   always_comb begin
      err_in = ERR_OK;
      if (accept && (op_type'(req_operation) == OP_PUSH) && is_full) begin
         err_in = ERR_FULL;
      end else if (accept && (op_type'(req_operation) == OP_POP) && is_empty) begin
         err_in = ERR_EMPTY;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         assign occ[gi] = (count_type'(gi) < count_ff);
         spq_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .new_value  (value_type'(req_value)),
            .occupied   (occ[gi]),
            .prev_gt    ((gi == 0) ? 1'b0 : gt[(gi == 0) ? 0 : gi - 1]),
            .prev_value (val_q[(gi == 0) ? 0 : gi - 1]),
            .next_value (val_q[(gi == DEPTH - 1) ? gi : gi + 1]),
            .gt         (gt[gi]),
            .value_q    (val_q[gi]),
            .value_next (val_next[gi])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      popped_ff    <= pop_ok ? val_q[0] : '0;
      top_ff       <= (count_in != '0) ? val_next[0] : '0;
      top_valid_ff <= (count_in != '0);
      count_rsp_ff <= count_in;
      err_ff       <= err_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_popped_value = 32'(popped_ff);
   assign rsp_top_value    = 32'(top_ff);
   assign rsp_top_valid    = top_valid_ff;
   assign rsp_entry_count  = 5'(count_rsp_ff);
   assign rsp_error_code   = 2'(err_ff);

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(DEPTH))
      else $error("entry count beyond depth");

   a_strobe_follows : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted transaction without response");

   a_full_error : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && err_ff == ERR_FULL) |-> count_rsp_ff == count_type'(DEPTH))
      else $error("full error with room left");

   a_empty_error : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && err_ff == ERR_EMPTY) |-> !rsp_top_valid)
      else $error("empty error with entries stored");

   a_order : assert property (@(posedge clock) disable iff (reset)
      (count_ff >= count_type'(2)) |-> val_q[0] >= val_q[1])
      else $error("cell order broken");

endmodule

>>> sim/sorted_priority_queue_tb.sv
// Testbench for sorted_priority_queue: random push/pop traffic checked against a shadow store.
`timescale 1ns / 1ps
module sorted_priority_queue_tb;
   import spq_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_OPS  = 1800;

   typedef struct {
      op_type    op;
      value_type value;
   } queue_op_type;

   typedef struct {
      value_type popped;
      value_type top;
      logic      top_valid;
      count_type entry_count;
      err_type   err;
   } queue_status_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_operation = OP_PUSH;
   logic signed [31:0]  req_value = '0;
   logic                rsp_strobe;
   logic signed [31:0]  rsp_popped_value;
   logic signed [31:0]  rsp_top_value;
   logic                rsp_top_valid;
   logic [4:0]          rsp_entry_count;
   logic [1:0]          rsp_error_code;

   queue_op_type     ops_to_send[$];
   queue_status_type awaited_status[$];
   value_type        shadow_entries[DEPTH];
   int               shadow_count = 0;
   int               total_ops = 0;
   int               accepted_ops = 0;
   int               mismatch_total = 0;
   int               cycle_count = 0;
   int               burst_left = 0;
   int               gap_left = 0;
   queue_op_type     next_op;
   queue_status_type seen;

   sorted_priority_queue uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_value        (req_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_popped_value (rsp_popped_value),
      .rsp_top_value    (rsp_top_value),
      .rsp_top_valid    (rsp_top_valid),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_error_code   (rsp_error_code)
   );

   always #2 clock = ~clock;

   // Sorted insert / remove-largest on the shadow store, returns the expected status.
   function automatic queue_status_type predict_queue_op(op_type op, value_type v);
      queue_status_type st;
      int pos;
      st.popped = '0;
      st.err    = ERR_OK;
      if (op == OP_PUSH) begin
         if (shadow_count >= DEPTH) begin
            st.err = ERR_FULL;
         end else begin
            pos = shadow_count;
            while (pos > 0 && shadow_entries[pos-1] > v) begin
               shadow_entries[pos] = shadow_entries[pos-1];
               pos--;
            end
            shadow_entries[pos] = v;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            st.err = ERR_EMPTY;
         end else begin
            st.popped = shadow_entries[shadow_count-1];
            shadow_count--;
         end
      end
      st.top         = (shadow_count > 0) ? shadow_entries[shadow_count-1] : '0;
      st.top_valid   = (shadow_count > 0);
      st.entry_count = count_type'(shadow_count);
      return st;
   endfunction

   function automatic value_type pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return value_type'($urandom);
         5, 6, 7:       return value_type'($urandom_range(0, 16)) - 8;
         8:             return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                                    : 32'sh8000_0000 + $urandom_range(0, 3);
      endcase
   endfunction

   function automatic void add_op(op_type op, value_type v);
      queue_op_type t;
      t.op    = op;
      t.value = v;
      ops_to_send.push_back(t);
   endfunction

   // Driver: one transaction per accept, bursts separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            awaited_status.push_back(predict_queue_op(op_type'(req_operation), req_value));
            accepted_ops++;
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (ops_to_send.size() > 0) begin
               next_op = ops_to_send.pop_front();
               start         <= 1'b1;
               req_operation <= next_op.op;
               req_value     <= next_op.value;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobe is a response and must match the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (awaited_status.size() == 0) begin
            $error("response with no transaction outstanding");
            mismatch_total++;
         end else begin
            seen = awaited_status.pop_front();
            if (rsp_popped_value !== seen.popped) begin
               $error("popped_value: expected %0d, got %0d", seen.popped, rsp_popped_value);
               mismatch_total++;
            end
            if (rsp_top_value !== seen.top) begin
               $error("top_value: expected %0d, got %0d", seen.top, rsp_top_value);
               mismatch_total++;
            end
            if (rsp_top_valid !== seen.top_valid) begin
               $error("top_valid: expected %0d, got %0d", seen.top_valid, rsp_top_valid);
               mismatch_total++;
            end
            if (rsp_entry_count !== seen.entry_count) begin
               $error("entry_count: expected %0d, got %0d", seen.entry_count,
                      rsp_entry_count);
               mismatch_total++;
            end
            if (rsp_error_code !== seen.err) begin
               $error("error_code: expected %0d, got %0d", seen.err, rsp_error_code);
               mismatch_total++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL sorted_priority_queue");
      $finish;
   end

   initial begin
      int  phase_len;
      int  push_pct;
      int  made;
      // empty pop, fill with extremes and duplicates, push when full, partial drain
      add_op(OP_POP, 32'sd77);
      add_op(OP_PUSH, 32'sh7FFF_FFFF);
      add_op(OP_PUSH, 32'sh8000_0000);
      add_op(OP_PUSH, 32'sd0);
      add_op(OP_PUSH, -32'sd1);
      add_op(OP_PUSH, 32'sd1);
      add_op(OP_PUSH, 32'sh7FFF_FFFF);
      add_op(OP_PUSH, 32'sh8000_0000);
      add_op(OP_PUSH, 32'sh5555_5555);
      add_op(OP_PUSH, 32'shAAAA_AAAA);
      add_op(OP_PUSH, 32'sd0);
      repeat (6) add_op(OP_PUSH, value_type'($urandom));
      add_op(OP_PUSH, 32'sd5);
      repeat (4) add_op(OP_POP, value_type'($urandom));

      // alternate push-heavy and pop-heavy phases so the store hits full and empty
      made     = 0;
      push_pct = 15;
      while (made < RANDOM_OPS) begin
         phase_len = $urandom_range(10, 60);
         push_pct  = (push_pct > 50) ? $urandom_range(10, 30) : $urandom_range(70, 90);
         repeat (phase_len) begin
            if ($urandom_range(1, 100) <= push_pct)
               add_op(OP_PUSH, pick_value());
            else
               add_op(OP_POP, value_type'($urandom));
            made++;
         end
      end
      total_ops = ops_to_send.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (accepted_ops < total_ops) @(posedge clock);
      while (awaited_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (mismatch_total == 0)
         $display("PASS sorted_priority_queue");
      else
         $display("FAIL sorted_priority_queue");
      $finish;
   end

endmodule

>>> sim.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
sim/sorted_priority_queue_tb.sv
